[hw/rtl/afu_pkg.sv]
// ----------------------------------------------------------------------------
// afu_pkg
// Shared constants, function codes and fixed-point helpers for the
// activation function unit.
// ----------------------------------------------------------------------------
package afu_pkg;

    // external format: signed Q4.12
    localparam int VW = 16;
    localparam int FB = 12;
    localparam int AW = VW + 1;                 // magnitude incl. 2^(VW-1)

    // internal unsigned Q1.30
    localparam int IF = 30;
    localparam int QW = IF + 1;
    localparam logic [QW-1:0] ONE = QW'(1) << IF;
    localparam logic [63:0] ONE64 = 64'd1 << IF;

    localparam int SERIES_TERMS = 12;
    localparam int NBITS_INT    = 5;            // integer part of exp argument
    localparam int EXP_LAT      = 1 + SERIES_TERMS + NBITS_INT;
    localparam int DIV_STEPS    = QW;
    localparam int DIV_LAT      = (DIV_STEPS + 1) / 2;

    // 1/k in Q1.30 for the series
    localparam logic [QW-1:0] RECIP [1:SERIES_TERMS] = '{
        QW'(ONE64 / 64'd1),  QW'(ONE64 / 64'd2),  QW'(ONE64 / 64'd3),
        QW'(ONE64 / 64'd4),  QW'(ONE64 / 64'd5),  QW'(ONE64 / 64'd6),
        QW'(ONE64 / 64'd7),  QW'(ONE64 / 64'd8),  QW'(ONE64 / 64'd9),
        QW'(ONE64 / 64'd10), QW'(ONE64 / 64'd11), QW'(ONE64 / 64'd12)
    };

    // e^-1, e^-2, e^-4, e^-8, e^-16 in Q1.30
    localparam logic [QW-1:0] EXPN [0:NBITS_INT-1] = '{
        QW'(395007542), QW'(145315154), QW'(19666268), QW'(360200), QW'(121)
    };

    // function codes
    localparam logic [2:0] FN_SIGMOID = 3'd0;
    localparam logic [2:0] FN_SWISH   = 3'd1;
    localparam logic [2:0] FN_RELU    = 3'd2;
    localparam logic [2:0] FN_LEAKY   = 3'd3;
    localparam logic [2:0] FN_TANH    = 3'd4;
    localparam logic [2:0] FN_HTANH   = 3'd5;

    // register indexes
    localparam logic REG_KIND  = 1'b0;
    localparam logic REG_DERIV = 1'b1;

    // leaky slope: floor(v/100) = (v*5243) >> 19 for v < 43690
    localparam int LK_RND = 50;
    localparam int LK_MUL = 5243;
    localparam int LK_SH  = 19;
    localparam logic [VW-1:0] ONE_OUT   = VW'(1) << FB;
    localparam logic [VW-1:0] LK_DERIV  = VW'(((1 << FB) + LK_RND) / 100);

    typedef logic [QW-1:0] q_t;

    // Q1.30 product, truncated
    function automatic q_t qmul(input q_t a, input q_t b);
        logic [2*QW-1:0] p;
        begin
            p = a * b;
            return p[IF+QW-1:IF];
        end
    endfunction

    // Q.12 fraction times Q1.30 constant, result Q1.30
    function automatic q_t fmul(input logic [FB-1:0] f, input q_t r);
        logic [FB+QW-1:0] p;
        begin
            p = f * r;
            return p[FB+QW-1:FB];
        end
    endfunction

    // Q1.30 magnitude to Q.12, half away from zero
    function automatic logic [AW:0] rnd(input logic [IF+3:0] v);
        logic [IF+4:0] s;
        begin
            s = {1'b0, v} + ((IF+5)'(1) << (IF - FB - 1));
            return (AW+1)'(s >> (IF - FB));
        end
    endfunction

    // sign and magnitude to saturated two's complement
    function automatic logic [VW-1:0] sat(input logic neg, input logic [AW:0] mag);
        logic [AW:0] maxp;
        logic [AW:0] m;
        begin
            maxp = (AW+1)'((1 << (VW - 1)) - 1);
            if (!neg)
            begin
                return (mag > maxp) ? VW'(maxp) : VW'(mag);
            end
            m = (mag > maxp + 1'b1) ? maxp + 1'b1 : mag;
            return VW'(-m);
        end
    endfunction

endpackage

[hw/rtl/afu_exp.sv]
// ----------------------------------------------------------------------------
// afu_exp
// Pipelined e^-t, t unsigned Q5.12: Horner series on the fraction, then
// one conditional multiply per bit of the integer part.
// ----------------------------------------------------------------------------
module afu_exp
(
    input  logic                 clk,
    input  logic                 ce,
    input  logic [afu_pkg::AW-1:0] t,
    output afu_pkg::q_t          e
);

    localparam int K  = afu_pkg::SERIES_TERMS;
    localparam int NB = afu_pkg::NBITS_INT;

    afu_pkg::q_t            acc_reg [0:K];
    afu_pkg::q_t            g_reg   [0:K-1];
    logic [afu_pkg::FB-1:0] f_reg   [0:K];
    logic [NB-1:0]          n_reg   [0:K];
    afu_pkg::q_t            sc_reg  [0:NB-1];
    logic [NB-1:0]          nsc_reg [0:NB-1];

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            f_reg[0]   <= t[afu_pkg::FB-1:0];
            n_reg[0]   <= t[afu_pkg::AW-1:afu_pkg::FB];
            acc_reg[0] <= afu_pkg::ONE;
            g_reg[0]   <= afu_pkg::fmul(t[afu_pkg::FB-1:0], afu_pkg::RECIP[K]);
        end
    end

    // acc = 1 - (f/k)*acc, k from K down to 1
    for (genvar j = 1; j <= K; j++)
    begin : g_series
        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                acc_reg[j] <= afu_pkg::ONE - afu_pkg::qmul(g_reg[j-1], acc_reg[j-1]);
                f_reg[j]   <= f_reg[j-1];
                n_reg[j]   <= n_reg[j-1];
            end
        end
        if (j < K)
        begin : g_next
            always_ff @(posedge clk)
            begin
                if (ce)
                begin
                    g_reg[j] <= afu_pkg::fmul(f_reg[j-1], afu_pkg::RECIP[K-j]);
                end
            end
        end
    end

    for (genvar b = 0; b < NB; b++)
    begin : g_scale
        afu_pkg::q_t   src;
        logic [NB-1:0] nsrc;
        if (b == 0)
        begin : g_first
            assign src  = acc_reg[K];
            assign nsrc = n_reg[K];
        end
        else
        begin : g_rest
            assign src  = sc_reg[b-1];
            assign nsrc = nsc_reg[b-1];
        end
        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                sc_reg[b]  <= nsrc[b] ? afu_pkg::qmul(src, afu_pkg::EXPN[b]) : src;
                nsc_reg[b] <= nsrc;
            end
        end
    end

    assign e = sc_reg[NB-1];

endmodule

[hw/rtl/afu_div.sv]
// ----------------------------------------------------------------------------
// afu_div
// Pipelined restoring divider, two quotient bits per stage.
// quo = floor(num * 2^30 / den), num <= den, den in [1.0, 2.0].
// ----------------------------------------------------------------------------
module afu_div
(
    input  logic                  clk,
    input  logic                  ce,
    input  afu_pkg::q_t           num,
    input  logic [afu_pkg::QW:0]  den,
    output afu_pkg::q_t           quo
);

    localparam int NS = afu_pkg::DIV_LAT;
    localparam int RW = afu_pkg::QW + 2;

    logic [RW-1:0]          r_reg [0:NS-1];
    afu_pkg::q_t            q_reg [0:NS-1];
    logic [afu_pkg::QW:0]   d_reg [0:NS-1];

    for (genvar s = 0; s < NS; s++)
    begin : g_stage
        logic [RW-1:0]        r_in;
        afu_pkg::q_t          q_in;
        logic [afu_pkg::QW:0] d_in;
        logic [RW-1:0]        r_next;
        afu_pkg::q_t          q_next;

        if (s == 0)
        begin : g_first
            assign r_in = RW'(num);
            assign q_in = '0;
            assign d_in = den;
        end
        else
        begin : g_rest
            assign r_in = r_reg[s-1];
            assign q_in = q_reg[s-1];
            assign d_in = d_reg[s-1];
        end

        always_comb
        begin
            r_next = r_in;
            q_next = q_in;
            for (int i = 0; i < 2; i++)
            begin
                if (2 * s + i < afu_pkg::DIV_STEPS)
                begin
                    // first step weighs 1.0, no shift
                    if (2 * s + i != 0)
                    begin
                        r_next = r_next << 1;
                    end
                    if (r_next >= RW'(d_in))
                    begin
                        r_next = r_next - RW'(d_in);
                        q_next = {q_next[afu_pkg::QW-2:0], 1'b1};
                    end
                    else
                    begin
                        q_next = {q_next[afu_pkg::QW-2:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                r_reg[s] <= r_next;
                q_reg[s] <= q_next;
                d_reg[s] <= d_in;
            end
        end
    end

    assign quo = q_reg[NS-1];

endmodule

[hw/rtl/activation_function_unit.sv]
// ----------------------------------------------------------------------------
// activation_function_unit
// Element-wise sigmoid, swish, ReLU, leaky ReLU, tanh and hard tanh, forward
// value or derivative, on signed Q4.12 words.
// ----------------------------------------------------------------------------
// Usage:
//   Input words arrive on s_tdata (x_value) with s_tlast; results leave on
//   m_tdata (y_value) with m_tlast copied from the input word.
//   function_kind (addr 0) and derivative_mode (addr 4) are set over APB
//   while no words are in flight; both clear to 0 at reset.
// Timing:
//   One word per cycle while the output is not stalled. A word passes 39
//   register stages: 1 input stage, 18 for e^-t (an entry register, 12
//   series terms and 5 integer scaling steps), 1 divider setup, 16 for
//   the 2-bit-per-stage divider, 2 post-multiply stages and the output
//   register.
// Reset clears all valid bits and the configuration registers. When m_tready is low with
// a word on the output, the whole pipeline holds and s_tready drops; no word
// is lost or repeated.
// ----------------------------------------------------------------------------
module activation_function_unit
(
    input  logic        clk,
    input  logic        rst_n,
    // APB
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] x_value
    input  logic        s_tlast,
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] y_value
    output logic        m_tlast
);

    localparam int AW      = afu_pkg::AW;
    localparam int IDX_E   = afu_pkg::EXP_LAT;
    localparam int IDX_P   = IDX_E + 1;
    localparam int IDX_D   = IDX_P + afu_pkg::DIV_LAT;
    localparam int IDX_C1  = IDX_D + 1;
    localparam int IDX_C2  = IDX_D + 2;
    localparam int SB_LEN  = IDX_C2 + 1;

    logic [2:0]  kind_reg;
    logic        deriv_reg;

    logic        vld_reg  [0:SB_LEN-1];
    logic        last_sb  [0:SB_LEN-1];
    logic        neg_sb   [0:SB_LEN-1];
    logic [AW-1:0] a_sb   [0:SB_LEN-1];

    logic        ce;
    logic        wr_en;

    logic [15:0] x_in;
    logic        x_neg;
    logic [AW-1:0] x_mag;
    logic [AW-1:0] t_reg;

    afu_pkg::q_t          e_out;
    afu_pkg::q_t          num_reg;
    logic [afu_pkg::QW:0] den_reg;
    afu_pkg::q_t          quo;

    afu_pkg::q_t p1_reg, q1_reg, mm1_reg;
    afu_pkg::q_t p2_reg, q2_reg, mm2_reg;
    logic [afu_pkg::IF+3:0] m2_reg;
    logic [AW+afu_pkg::QW-1:0] sw2_reg;
    logic [AW-1:0] lk2_reg;

    logic [AW+afu_pkg::QW-1:0] m_prod;
    logic [AW+afu_pkg::QW-1:0] sw_prod;
    logic [AW+13:0]            lk_prod;
    logic [AW+afu_pkg::QW:0]   sw_rnd;

    logic        out_vld_reg;
    logic [15:0] y_reg;
    logic [15:0] y_next;
    logic        last_reg;

    // ---------------- configuration ----------------
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == afu_pkg::REG_DERIV) ? {31'b0, deriv_reg} : {29'b0, kind_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg  <= afu_pkg::FN_SIGMOID;
            deriv_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                afu_pkg::REG_KIND:  kind_reg  <= pwdata[2:0];
                afu_pkg::REG_DERIV: deriv_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    // ---------------- flow control ----------------
    assign ce       = m_tready | ~out_vld_reg;
    assign s_tready = ce;

    // ---------------- input stage ----------------
    assign x_in  = s_tdata;
    assign x_neg = x_in[15];
    assign x_mag = x_neg ? AW'(-$signed({x_in[15], x_in})) : AW'(x_in);

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            t_reg <= (kind_reg == afu_pkg::FN_TANH) ? AW'(x_mag << 1) : x_mag;
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < SB_LEN; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (ce)
        begin
            vld_reg[0] <= s_tvalid;
            for (int k = 1; k < SB_LEN; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // sideband travelling with each word
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            last_sb[0] <= s_tlast;
            neg_sb[0]  <= x_neg;
            a_sb[0]    <= x_mag;
            for (int k = 1; k < SB_LEN; k++)
            begin
                last_sb[k] <= last_sb[k-1];
                neg_sb[k]  <= neg_sb[k-1];
                a_sb[k]    <= a_sb[k-1];
            end
        end
    end

    // ---------------- e^-t ----------------
    afu_exp u_exp
    (
        .clk (clk),
        .ce  (ce),
        .t   (t_reg),
        .e   (e_out)
    );

    // sigmoid: 1/(1+e); tanh: (1-e)/(1+e) with e = e^-2|x|
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            den_reg <= {1'b0, afu_pkg::ONE} + {1'b0, e_out};
            num_reg <= (kind_reg == afu_pkg::FN_TANH) ? afu_pkg::ONE - e_out : afu_pkg::ONE;
        end
    end

    afu_div u_div
    (
        .clk (clk),
        .ce  (ce),
        .num (num_reg),
        .den (den_reg),
        .quo (quo)
    );

    // ---------------- post-processing ----------------
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            p1_reg  <= quo;
            q1_reg  <= afu_pkg::ONE - quo;
            mm1_reg <= (kind_reg == afu_pkg::FN_TANH) ? afu_pkg::qmul(quo, quo)
                                                      : afu_pkg::qmul(quo, afu_pkg::ONE - quo);
        end
    end

    assign m_prod  = a_sb[IDX_C1] * mm1_reg;
    assign sw_prod = a_sb[IDX_C1] * (neg_sb[IDX_C1] ? q1_reg : p1_reg);
    assign lk_prod = (AW + 14)'((AW + 1)'(a_sb[IDX_C1]) + (AW + 1)'(afu_pkg::LK_RND))
                   * (AW + 14)'(afu_pkg::LK_MUL);

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            p2_reg  <= p1_reg;
            q2_reg  <= q1_reg;
            mm2_reg <= mm1_reg;
            m2_reg  <= (afu_pkg::IF + 4)'(m_prod >> afu_pkg::FB);
            sw2_reg <= sw_prod;
            lk2_reg <= AW'(lk_prod >> afu_pkg::LK_SH);
        end
    end

    assign sw_rnd = {1'b0, sw2_reg} + ((AW + afu_pkg::QW + 1)'(1) << (afu_pkg::IF - 1));

    always_comb
    begin
        logic          ng;
        logic [AW-1:0] a;
        ng = neg_sb[IDX_C2];
        a  = a_sb[IDX_C2];
        y_next = '0;
        case (kind_reg)
            afu_pkg::FN_SIGMOID:
            begin
                if (deriv_reg)
                    y_next = afu_pkg::sat(1'b0, afu_pkg::rnd(34'(mm2_reg)));
                else
                    y_next = afu_pkg::sat(1'b0, afu_pkg::rnd(34'(ng ? q2_reg : p2_reg)));
            end
            afu_pkg::FN_SWISH:
            begin
                if (!deriv_reg)
                    y_next = afu_pkg::sat(ng, (AW + 1)'(sw_rnd >> afu_pkg::IF));
                else if (!ng)
                    y_next = afu_pkg::sat(1'b0, afu_pkg::rnd(34'(p2_reg) + m2_reg));
                else if (34'(q2_reg) >= m2_reg)
                    y_next = afu_pkg::sat(1'b0, afu_pkg::rnd(34'(q2_reg) - m2_reg));
                else
                    y_next = afu_pkg::sat(1'b1, afu_pkg::rnd(m2_reg - 34'(q2_reg)));
            end
            afu_pkg::FN_RELU:
            begin
                if (deriv_reg)
                    y_next = (!ng && a != '0) ? afu_pkg::ONE_OUT : '0;
                else
                    y_next = (!ng) ? afu_pkg::sat(1'b0, (AW + 1)'(a)) : '0;
            end
            afu_pkg::FN_LEAKY:
            begin
                if (deriv_reg)
                    y_next = (!ng) ? afu_pkg::ONE_OUT : afu_pkg::LK_DERIV;
                else if (!ng && a != '0)
                    y_next = afu_pkg::sat(1'b0, (AW + 1)'(a));
                else
                    y_next = afu_pkg::sat(1'b1, (AW + 1)'(lk2_reg));
            end
            afu_pkg::FN_TANH:
            begin
                if (deriv_reg)
                    y_next = afu_pkg::sat(1'b0, afu_pkg::rnd(34'(afu_pkg::ONE - mm2_reg)));
                else
                    y_next = afu_pkg::sat(ng, afu_pkg::rnd(34'(p2_reg)));
            end
            afu_pkg::FN_HTANH:
            begin
                if (deriv_reg)
                    y_next = (a < AW'(afu_pkg::ONE_OUT)) ? afu_pkg::ONE_OUT : '0;
                else
                    y_next = afu_pkg::sat(ng, (a > AW'(afu_pkg::ONE_OUT))
                                              ? (AW + 1)'(afu_pkg::ONE_OUT)
                                              : (AW + 1)'(a));
            end
            default: y_next = '0;
        endcase
    end

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (ce)
        begin
            out_vld_reg <= vld_reg[IDX_C2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            y_reg    <= y_next;
            last_reg <= last_sb[IDX_C2];
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = y_reg;
    assign m_tlast  = last_reg;

endmodule
